// ----- design/cxr_pkg.sv -----
`timescale 1ns / 1ps

package cxr_pkg;

  // Field widths of the channels and the configuration register.
  localparam int CipherWidth = 8;
  localparam int LengthWidth = 16;
  localparam int CheckCount  = 4;
  localparam int PhaseWidth  = 4;
  localparam int TrailWidth  = 2;

  localparam int KeyLen = 10;

  // Reset values of the register and of the running checks.
  localparam logic [LengthWidth-1:0] LengthReset = 16'd1;
  localparam logic [PhaseWidth-1:0]  PhaseReset  = 4'd1;
  localparam logic [7:0]             MulSeed     = 8'd1;

  // Last key phase before it wraps to zero.
  localparam logic [PhaseWidth-1:0] PhaseLast = 4'(KeyLen - 1);

  // Trailer slots, in the order the check bytes arrive.
  localparam logic [TrailWidth-1:0] TrailAdd = 2'd0;
  localparam logic [TrailWidth-1:0] TrailSub = 2'd1;
  localparam logic [TrailWidth-1:0] TrailMul = 2'd2;
  localparam logic [TrailWidth-1:0] TrailXor = 2'd3;

  // One result item as it sits in the output register.
  typedef struct packed {
    logic                   is_verdict;
    logic [CipherWidth-1:0] plain_byte;
    logic                   record_ok;
    logic [CheckCount-1:0]  mismatch_mask;
  } result_t;

  // Key byte for a phase; phases past the key length fall back to the byte of phase zero.
  function automatic logic [7:0] key_byte(input logic [PhaseWidth-1:0] phase);
    logic [7:0] k;
    begin
      case (phase)
        4'd1:    k = 8'd23;
        4'd2:    k = 8'd16;
        4'd3:    k = 8'd192;
        4'd4:    k = 8'd254;
        4'd5:    k = 8'd82;
        4'd6:    k = 8'd113;
        4'd7:    k = 8'd147;
        4'd8:    k = 8'd62;
        4'd9:    k = 8'd99;
        default: k = 8'd58;
      endcase
      return k;
    end
  endfunction

endpackage

// ----- design/cxr_if.sv -----
`timescale 1ns / 1ps

// Channel carrying ciphertext bytes into the block.
interface cxr_in_if
  import cxr_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic [CipherWidth-1:0] cipher_byte;

  modport source (output valid, output cipher_byte, input ready);
  modport sink (input valid, input cipher_byte, output ready);
endinterface

// Channel carrying plaintext bytes and record verdicts out of the block.
interface cxr_out_if
  import cxr_pkg::*;
  ();
  logic                   valid;
  logic                   ready;
  logic                   is_verdict;
  logic [CipherWidth-1:0] plain_byte;
  logic                   record_ok;
  logic [CheckCount-1:0]  mismatch_mask;

  modport source (output valid, output is_verdict, output plain_byte,
                  output record_ok, output mismatch_mask, input ready);
  modport sink (input valid, input is_verdict, input plain_byte,
                input record_ok, input mismatch_mask, output ready);
endinterface

// ----- design/chained_xor_record_decrypt_check_top.sv -----
`timescale 1ns / 1ps

// Chained XOR record decryptor with a four-way integrity check.
// The din channel takes one ciphertext byte per item: record_length body
// bytes, then four check bytes (add, subtract, multiply hash, xor).
// Each body byte yields one plaintext item on dout. The first three check
// bytes yield nothing; the fourth yields a verdict item with record_ok and
// a mismatch mask, after which the block rearms for the next record.
// The user must write the length register through cfg_we/cfg_data only
// while idle; the block does not enforce this. One byte is taken every
// cycle while din is ready; a single pass of logic carries each accepted
// byte into the state registers and the output register or skid entry.
// An output register plus one skid entry parts the two sides, so din stays
// ready while a result waits; din drops ready only when both hold items.
// Reset (rst, synchronous) sets record_length to 1, clears both output
// entries and returns the key phase, chaining and checks to their seeds.
module chained_xor_record_decrypt_check_top
  import cxr_pkg::*;
  (
  input  logic                   clk,
  input  logic                   rst,
  cxr_in_if.sink                 din,
  cxr_out_if.source              dout,
  input  logic                   cfg_we,
  input  logic [LengthWidth-1:0] cfg_data
);

  logic [LengthWidth-1:0] record_length;
  logic [LengthWidth-1:0] byte_position;
  logic [TrailWidth-1:0]  trailer_count;
  logic [PhaseWidth-1:0]  key_phase;
  logic [7:0]             previous_cipher;
  logic [7:0]             add_check;
  logic [7:0]             sub_check;
  logic [7:0]             mul_check;
  logic [7:0]             xor_check;
  logic [CheckCount-1:0]  fail_bits;

  logic                   out_valid;
  result_t                out_item;
  logic                   skid_valid;
  result_t                skid_item;

  logic                   accept;
  logic                   pop;
  logic                   push;
  logic                   in_body;
  logic [7:0]             plain;
  logic [7:0]             product;
  logic [7:0]             expected;
  logic [CheckCount-1:0]  fail_next;
  result_t                new_item;

  assign accept = din.valid && din.ready;
  assign pop    = out_valid && dout.ready;
  assign in_body = byte_position < record_length;

  // Decrypt: key byte, chained with the previous ciphertext except at the start.
  always_comb begin
    plain = din.cipher_byte ^ key_byte(key_phase);
    if (byte_position != '0) begin
      plain = plain ^ previous_cipher;
    end
  end

  assign product = mul_check * plain;

  // Pick the running check that the current trailer byte is compared with.
  always_comb begin
    case (trailer_count)
      TrailAdd: expected = add_check;
      TrailSub: expected = sub_check;
      TrailMul: expected = mul_check;
      default:  expected = xor_check;
    endcase
  end

  always_comb begin
    fail_next = fail_bits;
    if (din.cipher_byte != expected) begin
      fail_next[trailer_count] = 1'b1;
    end
  end

  // Form the result item, if this byte causes one.
  always_comb begin
    new_item = '0;
    push     = 1'b0;
    if (in_body) begin
      new_item.plain_byte = plain;
      push                = accept;
    end else if (trailer_count == TrailXor) begin
      new_item.is_verdict    = 1'b1;
      new_item.record_ok     = (fail_next == '0);
      new_item.mismatch_mask = fail_next;
      push                   = accept;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      record_length <= LengthReset;
    end else if (cfg_we) begin
      record_length <= cfg_data;
    end
  end

  // Record state: body decryption, trailer compare and rearm after the verdict.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      trailer_count   <= '0;
      key_phase       <= PhaseReset;
      previous_cipher <= '0;
      add_check       <= '0;
      sub_check       <= '0;
      mul_check       <= MulSeed;
      xor_check       <= '0;
      fail_bits       <= '0;
    end else if (accept) begin
      if (in_body) begin
        add_check       <= add_check + plain;
        sub_check       <= sub_check - plain;
        mul_check       <= product + 8'd1;
        xor_check       <= xor_check ^ plain;
        previous_cipher <= din.cipher_byte;
        byte_position   <= byte_position + LengthWidth'(1);
        key_phase       <= (key_phase >= PhaseLast) ? '0 : key_phase + PhaseWidth'(1);
      end else if (trailer_count != TrailXor) begin
        trailer_count <= trailer_count + TrailWidth'(1);
        fail_bits     <= fail_next;
      end else begin
        byte_position   <= '0;
        trailer_count   <= '0;
        key_phase       <= PhaseReset;
        previous_cipher <= '0;
        add_check       <= '0;
        sub_check       <= '0;
        mul_check       <= MulSeed;
        xor_check       <= '0;
        fail_bits       <= '0;
      end
    end
  end

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_item  <= skid_item;
        skid_item <= new_item;
      end else begin
        out_item <= new_item;
      end
    end else if (push) begin
      skid_item <= new_item;
    end
  end

  assign din.ready          = !skid_valid;
  assign dout.valid         = out_valid;
  assign dout.is_verdict    = out_item.is_verdict;
  assign dout.plain_byte    = out_item.plain_byte;
  assign dout.record_ok     = out_item.record_ok;
  assign dout.mismatch_mask = out_item.mismatch_mask;

endmodule
